// ===== src/assert_macros.svh =====
// assertion macros used by the top level rtl file
// no dependencies; the checks compile out when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define Y2R_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

`define Y2R_NEVER(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) !(prop)) \
      else $error("forbidden condition seen");

`else

`define Y2R_ASSERT(label, clk, rst, prop)

`define Y2R_NEVER(label, clk, rst, prop)

`endif

`endif

// ===== src/y2r_pkg.sv =====
// types and constants shared by the yuv411 to rgb converter
// no dependencies
package y2r_pkg;

   localparam int LUMA_W        = 8;
   localparam int PIX_PER_GROUP = 4;
   localparam int IDX_W         = 2;
   localparam int FRAC_BITS     = 12;
   localparam int CT_W          = 22;
   localparam int ACC_W         = 24;

   localparam logic signed [CT_W-1:0] COEF_RV = 22'sd5743;
   localparam logic signed [CT_W-1:0] COEF_GU = 22'sd1411;
   localparam logic signed [CT_W-1:0] COEF_GV = 22'sd2925;
   localparam logic signed [CT_W-1:0] COEF_BU = 22'sd7258;
   localparam logic signed [ACC_W-1:0] ROUND_Q12 = 24'sd2048;
   localparam logic [LUMA_W-1:0] PIX_MAX = 8'd255;

   typedef struct packed {
      logic signed [CT_W-1:0]                   rv;
      logic signed [CT_W-1:0]                   gu;
      logic signed [CT_W-1:0]                   gv;
      logic signed [CT_W-1:0]                   bu;
      logic [PIX_PER_GROUP-1:0][LUMA_W-1:0]     luma;
      logic                                     skip;
   } group_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

// ===== src/yuv411_to_rgb_converter_top.sv =====
// yuv411 to rgb converter, top level: front end, group queue, pixel back end
// a group passes the front register and a queue entry before the back end registers its first pixel
// a group gives 4 pixels (2 with skip_pair), one pixel per cycle on rsp while rsp_stall is low
// the front accepts a new group every cycle while the queue has room
// reset: synchronous, active high; clears handshake state and skip_pair to 0
`include "assert_macros.svh"
module yuv411_to_rgb_converter_top import y2r_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [7:0]  req_u_chroma,
   input  logic [7:0]         req_y_first,
   input  logic signed [7:0]  req_v_chroma,
   input  logic [7:0]         req_y_second,
   input  logic [7:0]         req_y_third,
   input  logic [7:0]         req_y_fourth,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_red,
   output logic [7:0]         rsp_green,
   output logic [7:0]         rsp_blue,
   output logic               rsp_group_end,
   input  logic               csr_write_enable,
   input  logic               csr_write_data
);

   logic          skip_pair_ff, skip_pair_in;
   logic          q_push, q_pop;
   group_type     q_push_data, q_head;
   q_status_type  q_status;

   assign skip_pair_in = csr_write_enable ? csr_write_data : skip_pair_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_pair_ff <= 1'b0;
      end else begin
         skip_pair_ff <= skip_pair_in;
      end
   end

   y2r_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_u_chroma (req_u_chroma),
      .req_y_first  (req_y_first),
      .req_v_chroma (req_v_chroma),
      .req_y_second (req_y_second),
      .req_y_third  (req_y_third),
      .req_y_fourth (req_y_fourth),
      .skip_pair    (skip_pair_ff),
      .q_status     (q_status),
      .q_push       (q_push),
      .q_push_data  (q_push_data)
   );

   y2r_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .head_data (q_head),
      .status    (q_status)
   );

   y2r_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_data     (q_head),
      .q_status      (q_status),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_red       (rsp_red),
      .rsp_green     (rsp_green),
      .rsp_blue      (rsp_blue),
      .rsp_group_end (rsp_group_end)
   );

   // a group's pixels leave without gaps once the first one is taken
   `Y2R_ASSERT(a_group_no_gap, clock, reset, rsp_valid && !rsp_stall && !rsp_group_end |=> rsp_valid)
   `Y2R_NEVER(a_queue_status, clock, reset, q_status.full && q_status.empty)
   `Y2R_ASSERT(a_rsp_from_queue, clock, reset, $rose(rsp_valid) |-> $past(!q_status.empty))

endmodule

// ===== src/y2r_front.sv =====
// front end: accepts a group, forms the chroma products, hands it to the queue
// depends on y2r_pkg
module y2r_front import y2r_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [7:0]        req_u_chroma,
   input  logic [7:0]               req_y_first,
   input  logic signed [7:0]        req_v_chroma,
   input  logic [7:0]               req_y_second,
   input  logic [7:0]               req_y_third,
   input  logic [7:0]               req_y_fourth,
   input  logic                     skip_pair,
   input  q_status_type             q_status,
   output logic                     q_push,
   output group_type                q_push_data
);

   logic        front_valid_ff, front_valid_in;
   group_type   front_data_ff, front_data_in;
   logic        advance;
   logic signed [CT_W-1:0] u_ext, v_ext;

   assign advance   = !front_valid_ff || !q_status.full;
   assign req_stall = !advance;
   assign q_push    = front_valid_ff && !q_status.full;
   assign q_push_data = front_data_ff;

   assign u_ext = CT_W'(req_u_chroma);
   assign v_ext = CT_W'(req_v_chroma);

   always_comb begin
      front_valid_in = advance ? req_valid : front_valid_ff;
      front_data_in  = front_data_ff;
      if (req_valid && advance) begin
         front_data_in.rv   = v_ext * COEF_RV;
         front_data_in.gu   = u_ext * COEF_GU;
         front_data_in.gv   = v_ext * COEF_GV;
         front_data_in.bu   = u_ext * COEF_BU;
         front_data_in.luma = {req_y_fourth, req_y_third, req_y_second, req_y_first};
         front_data_in.skip = skip_pair;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
      front_data_ff <= front_data_in;
   end

endmodule

// ===== src/y2r_queue.sv =====
// short fifo of prepared groups between front and back end
// depends on y2r_pkg
module y2r_queue import y2r_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  group_type    push_data,
   input  logic         pop,
   output group_type    head_data,
   output q_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   group_type               entry_ff [DEPTH];
   logic [PTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]        count_ff, count_in;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      ptr_next = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign head_data    = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== src/y2r_back.sv =====
// back end: walks the luma samples of the head group, one rgb pixel per cycle while rsp_stall is low
// depends on y2r_pkg
module y2r_back import y2r_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  group_type    head_data,
   input  q_status_type q_status,
   output logic         q_pop,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [7:0]   rsp_red,
   output logic [7:0]   rsp_green,
   output logic [7:0]   rsp_blue,
   output logic         rsp_group_end
);

   localparam logic [IDX_W-1:0] LAST_FULL = IDX_W'(PIX_PER_GROUP - 1);
   localparam logic [IDX_W-1:0] LAST_SKIP = IDX_W'(1);
   localparam int Q_W = ACC_W - FRAC_BITS;

   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               valid_ff, valid_in;
   logic [7:0]         red_ff, red_in;
   logic [7:0]         green_ff, green_in;
   logic [7:0]         blue_ff, blue_in;
   logic               end_ff, end_in;
   logic               load, take, last;
   logic signed [ACC_W-1:0] y_q, acc_r, acc_g, acc_b;

   function automatic logic [7:0] scale_clip(input logic signed [ACC_W-1:0] acc);
      logic [Q_W-1:0] q;
      q = acc[ACC_W-1:FRAC_BITS];
      if (q[Q_W-1]) begin
         scale_clip = '0;
      end else if (|q[Q_W-2:LUMA_W]) begin
         scale_clip = PIX_MAX;
      end else begin
         scale_clip = q[LUMA_W-1:0];
      end
   endfunction

   assign load  = !valid_ff || !rsp_stall;
   assign take  = load && !q_status.empty;
   assign last  = head_data.skip ? (idx_ff == LAST_SKIP) : (idx_ff == LAST_FULL);
   assign q_pop = take && last;

   assign y_q   = $signed(ACC_W'({head_data.luma[idx_ff], FRAC_BITS'(0)}));
   assign acc_r = y_q + ACC_W'(head_data.rv) + ROUND_Q12;
   assign acc_g = y_q - ACC_W'(head_data.gu) - ACC_W'(head_data.gv) + ROUND_Q12;
   assign acc_b = y_q + ACC_W'(head_data.bu) + ROUND_Q12;

   always_comb begin
      valid_in = load ? !q_status.empty : valid_ff;
      idx_in   = idx_ff;
      red_in   = red_ff;
      green_in = green_ff;
      blue_in  = blue_ff;
      end_in   = end_ff;
      if (take) begin
         idx_in   = last ? '0 : idx_ff + 1'b1;
         red_in   = scale_clip(acc_r);
         green_in = scale_clip(acc_g);
         blue_in  = scale_clip(acc_b);
         end_in   = last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
      red_ff   <= red_in;
      green_ff <= green_in;
      blue_ff  <= blue_in;
      end_ff   <= end_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_red       = red_ff;
   assign rsp_green     = green_ff;
   assign rsp_blue      = blue_ff;
   assign rsp_group_end = end_ff;

endmodule
